// File: hdl/swss_pkg.sv
// Shared types and constants for the sliding window sum of squares block.
`default_nettype none

package swss_pkg;

  localparam int RET_W          = 24;
  localparam int CFG_W          = 9;
  localparam int SUM_W          = 55;
  localparam int SQ_W           = 2 * RET_W - 1;
  localparam int WINDOW_MAX_DEF = 256;
  localparam int WINDOW_RESET   = 32;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

  // One classified return on its way from the front end to the accumulator.
  typedef struct packed {
    logic signed [RET_W-1:0] ret;
    logic signed [RET_W-1:0] old;
    logic                    sub;
    logic                    emit;
    logic                    last;
  } swss_item_t;

endpackage

`default_nettype wire

// File: hdl/swss_front.sv
// Front end: window register, fill tracking, return ring and old-sample fetch.
`default_nettype none

module swss_front #(
  parameter int WINDOW_MAX = swss_pkg::WINDOW_MAX_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic signed [swss_pkg::RET_W-1:0] in_return_value,
  input  wire logic                              in_series_end,
  input  wire logic                              cfg_write_en,
  input  wire logic        [swss_pkg::CFG_W-1:0] cfg_window_length,
  input  wire logic       [swss_pkg::QCNT_W-1:0] q_count,
  output      logic                              push,
  output      swss_pkg::swss_item_t              push_item
);
  import swss_pkg::*;

  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int EW = (CW > CFG_W) ? CW : CFG_W;
  localparam int W_RESET = (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET;

  logic [CW-1:0]          win_r, win_nxt;
  logic [CW-1:0]          fill_r, fill_nxt, fill_new;
  logic [AW-1:0]          wp_r, wp_nxt, old_addr;
  logic [CW:0]            old_ext;
  logic [EW-1:0]          cfg_ext;
  logic                   accept, sub, emit;
  logic                   f1_v_r;
  logic signed [RET_W-1:0] f1_ret_r;
  logic                   f1_sub_r, f1_emit_r, f1_last_r;
  logic signed [RET_W-1:0] ring_rd_r;
  logic signed [RET_W-1:0] ring [WINDOW_MAX];

  // Credit check ignores pops, so a transaction accepted here always finds room.
  assign in_stall = !rst_n ||
                    ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(f1_v_r) >= (QCNT_W+1)'(QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cfg_ext = EW'(cfg_window_length);
    if (cfg_ext == '0) begin
      win_nxt = CW'(1);
    end else if (cfg_ext > EW'(WINDOW_MAX)) begin
      win_nxt = CW'(WINDOW_MAX);
    end else begin
      win_nxt = CW'(cfg_ext);
    end
  end

  always_comb begin
    sub      = (fill_r >= win_r);
    fill_new = sub ? win_r : fill_r + CW'(1);
    emit     = (fill_new == win_r);
    if ((CW+1)'(wp_r) >= (CW+1)'(win_r)) begin
      old_ext = (CW+1)'(wp_r) - (CW+1)'(win_r);
    end else begin
      old_ext = (CW+1)'(wp_r) + (CW+1)'(WINDOW_MAX) - (CW+1)'(win_r);
    end
    old_addr = AW'(old_ext);
    wp_nxt   = (wp_r == AW'(WINDOW_MAX - 1)) ? '0 : wp_r + AW'(1);
    fill_nxt = in_series_end ? '0 : fill_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= CW'(W_RESET);
      fill_r <= '0;
      wp_r   <= '0;
      f1_v_r <= 1'b0;
    end else begin
      f1_v_r <= accept;
      if (cfg_write_en) begin
        win_r  <= win_nxt;
        fill_r <= '0;
      end else if (accept) begin
        fill_r <= fill_nxt;
        wp_r   <= wp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_ret_r  <= in_return_value;
      f1_sub_r  <= sub;
      f1_emit_r <= emit;
      f1_last_r <= in_series_end;
    end
  end

  // Read-first ring: at full window length the old sample sits at the write address.
  always_ff @(posedge clk) begin
    if (accept) begin
      ring[wp_r] <= in_return_value;
      ring_rd_r  <= ring[old_addr];
    end
  end

  assign push           = f1_v_r;
  assign push_item.ret  = f1_ret_r;
  assign push_item.old  = ring_rd_r;
  assign push_item.sub  = f1_sub_r;
  assign push_item.emit = f1_emit_r;
  assign push_item.last = f1_last_r;

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= win_r) else $error("fill count exceeds window length");

  a_cfg_clears_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_write_en |=> fill_r == '0) else $error("window write did not clear fill count");

endmodule

`default_nettype wire

// File: hdl/swss_queue.sv
// Short queue of classified returns between the front end and the accumulator.
`default_nettype none

module swss_queue (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire swss_pkg::swss_item_t        push_item,
  input  wire logic                        pop,
  output      swss_pkg::swss_item_t        head_item,
  output      logic                        empty,
  output      logic [swss_pkg::QCNT_W-1:0] count
);
  import swss_pkg::*;

  swss_item_t        entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign head_item = entry_r[rd_ptr_r];
  assign empty     = (count_r == '0);
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r != QCNT_W'(QUEUE_DEPTH)) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: hdl/swss_back.sv
// Back end: squares, running sum update and the result register.
`default_nettype none

module swss_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_write_en,
  input  wire swss_pkg::swss_item_t              head_item,
  input  wire logic                              empty,
  output      logic                              pop,
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic        [swss_pkg::SUM_W-1:0] out_window_sum
);
  import swss_pkg::*;

  logic                      adv;
  swss_item_t                b1_r;
  logic                      b1_v_r;
  logic                      b2_v_r, b2_sub_r, b2_emit_r, b2_last_r;
  logic        [SQ_W-1:0]    sq_new_r, sq_old_r;
  logic signed [2*RET_W-1:0] prod_new, prod_old;
  logic        [SUM_W-1:0]   sum_r, sum_nxt;
  logic                      out_valid_r;
  logic        [SUM_W-1:0]   out_sum_r;

  // The whole back end moves together whenever the result register can take a value.
  assign adv = !(out_valid_r && out_stall);
  assign pop = adv && !empty;

  assign prod_new = b1_r.ret * b1_r.ret;
  assign prod_old = b1_r.old * b1_r.old;

  assign sum_nxt = sum_r + SUM_W'(sq_new_r) - (b2_sub_r ? SUM_W'(sq_old_r) : SUM_W'(0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r      <= 1'b0;
      b2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
    end else begin
      if (adv) begin
        b1_v_r      <= !empty;
        b2_v_r      <= b1_v_r;
        out_valid_r <= b2_v_r && b2_emit_r;
      end
      if (cfg_write_en) begin
        sum_r <= '0;
      end else if (adv && b2_v_r) begin
        sum_r <= b2_last_r ? '0 : sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_r      <= head_item;
      sq_new_r  <= SQ_W'(prod_new);
      sq_old_r  <= SQ_W'(prod_old);
      b2_sub_r  <= b1_r.sub;
      b2_emit_r <= b1_r.emit;
      b2_last_r <= b1_r.last;
      out_sum_r <= sum_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_window_sum = out_sum_r;

  a_series_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && b2_v_r && b2_last_r) |=> sum_r == '0)
    else $error("running sum not cleared after series end");

  a_result_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !b2_v_r) |=> !out_valid_r) else $error("result without a transaction");

endmodule

`default_nettype wire

// File: hdl/sliding_window_sum_of_squares.sv
// Sliding window sum of squares over a stream of fixed-point returns.
//
// Input channel (in_valid / in_stall): one return per transaction, 24-bit
// two's complement with 20 fraction bits, plus a series-end mark.
// Output channel (out_valid / out_stall): the sum of squares of the last
// window_length returns, 55 bits with 40 fraction bits, one result for each
// return once the window is full.
// Configuration: cfg_write_en with cfg_window_length loads the window length
// (0 acts as 1, values above WINDOW_MAX act as WINDOW_MAX) and clears the
// window; write only while the block is idle.
// Throughput is one return per cycle while in_stall is low; a result passes
// in turn through the ring read stage, the queue, the operand register, the
// multiplier stage and the accumulator stage.
// Reset (rst_n low, synchronous) empties the window and the queue and sets the
// window length to 32 (WINDOW_MAX if smaller); ring contents are left as they are.
// When the receiver stalls, the result holds and the four-entry queue absorbs
// transactions until it fills; then in_stall rises.
`default_nettype none

module sliding_window_sum_of_squares #(
  parameter int WINDOW_MAX = swss_pkg::WINDOW_MAX_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic signed [swss_pkg::RET_W-1:0] in_return_value,
  input  wire logic                              in_series_end,
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic        [swss_pkg::SUM_W-1:0] out_window_sum,
  input  wire logic                              cfg_write_en,
  input  wire logic        [swss_pkg::CFG_W-1:0] cfg_window_length
);
  import swss_pkg::*;

  logic              push, pop, empty;
  swss_item_t        push_item, head_item;
  logic [QCNT_W-1:0] q_count;

  swss_front #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_return_value  (in_return_value),
    .in_series_end    (in_series_end),
    .cfg_write_en     (cfg_write_en),
    .cfg_window_length(cfg_window_length),
    .q_count          (q_count),
    .push             (push),
    .push_item        (push_item)
  );

  swss_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head_item(head_item),
    .empty    (empty),
    .count    (q_count)
  );

  swss_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_write_en  (cfg_write_en),
    .head_item     (head_item),
    .empty         (empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_window_sum(out_window_sum)
  );

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sliding window sum of squares block.
module testbench;
  import swss_pkg::*;

  localparam int RING_W = $clog2(WINDOW_MAX_DEF);
  localparam int LATENCY_WAIT = 8;
  localparam int DRAIN_LIMIT = 20000;
  localparam int HOLD_CYCLES = 200;
  localparam logic signed [RET_W-1:0] RET_MAX = {1'b0, {(RET_W-1){1'b1}}};
  localparam logic signed [RET_W-1:0] RET_MIN = {1'b1, {(RET_W-1){1'b0}}};
  localparam logic [CFG_W-1:0] CFG_ALL_ONES = '1;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [RET_W-1:0] in_return_value;
  logic in_series_end;
  logic out_valid;
  logic out_stall;
  logic [SUM_W-1:0] out_window_sum;
  logic cfg_write_en;
  logic [CFG_W-1:0] cfg_window_length;

  // Predictor state, mirrors the block.
  logic signed [RET_W-1:0] ret_history [WINDOW_MAX_DEF];
  logic [RING_W-1:0] write_pos;
  logic [CFG_W-1:0] fill_cnt;
  logic [SUM_W-1:0] run_sum;
  logic [CFG_W-1:0] window_len;
  logic [SUM_W-1:0] expected_sums [$];

  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_request = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  sliding_window_sum_of_squares u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_return_value  (in_return_value),
    .in_series_end    (in_series_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_window_sum   (out_window_sum),
    .cfg_write_en     (cfg_write_en),
    .cfg_window_length(cfg_window_length)
  );

  always #6 clk = ~clk;

  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [2*RET_W-1:0] square_return(input logic signed [RET_W-1:0] r);
    logic signed [2*RET_W-1:0] wide;
    wide = r;
    return wide * wide;
  endfunction

  function automatic logic [CFG_W-1:0] active_window();
    if (window_len == 0) return CFG_W'(1);
    if (window_len > WINDOW_MAX_DEF) return CFG_W'(WINDOW_MAX_DEF);
    return window_len;
  endfunction

  // Advances the predicted window by one return and queues the sum it yields.
  function automatic void predict_window_sum(input logic signed [RET_W-1:0] r,
                                             input logic last);
    logic [CFG_W-1:0] w;
    logic [RING_W-1:0] oldest;
    w = active_window();
    if (fill_cnt >= w) begin
      // A full ring of 256 wraps onto the slot about to be overwritten.
      oldest = write_pos - w[RING_W-1:0];
      run_sum = run_sum - SUM_W'(square_return(ret_history[oldest]));
      fill_cnt = w;
    end else begin
      fill_cnt = fill_cnt + 1'b1;
    end
    run_sum = run_sum + SUM_W'(square_return(r));
    ret_history[write_pos] = r;
    write_pos = write_pos + 1'b1;
    if (fill_cnt == w) expected_sums.push_back(run_sum);
    if (last) begin
      fill_cnt = '0;
      run_sum = '0;
    end
  endfunction

  // Receiver stall: a requested hold-off takes priority over random stalls.
  always @(posedge clk) begin
    if (hold_request != hold_served) begin
      hold_left = HOLD_CYCLES;
      hold_served = hold_request;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    logic [SUM_W-1:0] want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected result window_sum=%0h", out_window_sum));
      end else begin
        want = expected_sums.pop_front();
        if (out_window_sum !== want)
          report_mismatch($sformatf("window_sum got %0h want %0h", out_window_sum, want));
      end
    end
  end

  task automatic send_return(input logic signed [RET_W-1:0] value, input logic last);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_return_value <= value;
    in_series_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_window_sum(value, last);
  endtask

  task automatic drain_results();
    int unsigned waited;
    in_valid <= 1'b0;
    waited = 0;
    while (expected_sums.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_sums.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_sums.size()));
      expected_sums.delete();
    end
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] len);
    drain_results();
    cfg_window_length <= len;
    cfg_write_en <= 1'b1;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    window_len = len;
    fill_cnt = '0;
    run_sum = '0;
  endtask

  function automatic logic signed [RET_W-1:0] random_return();
    case ($urandom_range(9))
      0: return RET_MAX;
      1: return RET_MIN;
      2: return '0;
      3: return RET_W'($urandom_range(255));
      4: return -RET_W'($urandom_range(256, 1));
      default: return RET_W'($urandom);
    endcase
  endfunction

  task automatic test_reset_window();
    for (int i = 0; i < 40; i++) send_return(random_return(), 1'b0);
  endtask

  task automatic test_directed();
    write_window(CFG_W'(1));
    send_return(RET_MAX, 1'b0);
    send_return(RET_MIN, 1'b0);
    send_return('0, 1'b0);
    send_return(RET_W'(-1), 1'b0);
    send_return(RET_W'(1), 1'b1);
    // A zero length behaves as a window of one.
    write_window('0);
    send_return(RET_MIN, 1'b0);
    send_return(RET_W'(12345), 1'b1);
    write_window(CFG_W'(3));
    // The series ends before the window fills, so nothing comes out.
    send_return(RET_MAX, 1'b0);
    send_return(RET_MIN, 1'b1);
    // The window fills exactly on the last return of the series.
    send_return(RET_MIN, 1'b0);
    send_return(RET_MIN, 1'b0);
    send_return(RET_MAX, 1'b1);
    send_return(RET_MAX, 1'b0);
    send_return(RET_W'(-2), 1'b0);
    send_return(RET_W'(7), 1'b0);
    send_return(RET_MIN, 1'b0);
  endtask

  task automatic test_max_window();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_window(CFG_W'(WINDOW_MAX_DEF));
    for (int i = 0; i < 260; i++) send_return(random_return(), 1'b0);
    // Lengths above the ring size saturate to it.
    write_window(CFG_ALL_ONES);
    for (int i = 0; i < 270; i++) send_return(random_return(), 1'b0);
  endtask

  task automatic test_random_phase(input int unsigned send_pct, input int unsigned recv_pct);
    logic [CFG_W-1:0] len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int b = 0; b < 5; b++) begin
      case ($urandom_range(9))
        0: len = '0;
        1, 2: len = CFG_W'($urandom_range(64, 13));
        default: len = CFG_W'($urandom_range(12, 1));
      endcase
      write_window(len);
      for (int i = 0; i < 16; i++) send_return(random_return(), $urandom_range(29) == 0);
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_window(CFG_W'(4));
    hold_request = hold_request + 1;
    for (int i = 0; i < 40; i++) send_return(random_return(), 1'b0);
    // The sender waits here until the last result has been taken.
    drain_results();
    for (int i = 0; i < 10; i++) send_return(random_return(), 1'b0);
  endtask

  initial begin
    for (int i = 0; i < WINDOW_MAX_DEF; i++) ret_history[i] = '0;
    write_pos = '0;
    fill_cnt = '0;
    run_sum = '0;
    window_len = CFG_W'(WINDOW_RESET);
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_return_value <= '0;
    in_series_end <= 1'b0;
    cfg_write_en <= 1'b0;
    cfg_window_length <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_window();
    test_directed();
    test_max_window();
    test_random_phase(37, 77);
    test_random_phase(77, 37);
    test_random_phase(0, 0);
    test_backpressure();
    drain_results();

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
